### design/rgl_pkg.sv
// Shared types and constants for the rectilinear grid locator.
package rgl_pkg;

    localparam int MAX_CELLS_DEF = 256;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 24;
    localparam int VOL_W         = 63;
    localparam int CFG_W         = 9;
    localparam int SLOT_W        = 9;
    localparam int CELL_IN_W     = 8;
    localparam int CFG_ADDR_W    = 2;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_LOCATE = 2'd1,
        OP_CELL   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELLS_Z = 2'd2;

    typedef struct packed {
        logic wr;
        logic loc;
        logic ctr;
    } t_axis_cmd;

    typedef struct packed {
        logic done;
        logic found;
        logic edge_pos;
    } t_axis_stat;

    typedef enum logic [2:0] {
        SC_IDLE,
        SC_FIRST,
        SC_LAST,
        SC_SCAN,
        SC_CELL_A,
        SC_CELL_B,
        SC_DONE
    } t_scan_state;

    typedef enum logic [2:0] {
        V_IDLE,
        V_HI,
        V_LO,
        V_SUM,
        V_DONE
    } t_vol_state;

    typedef enum logic [2:0] {
        T_IDLE,
        T_AXES,
        T_IDX1,
        T_IDX2,
        T_VOL,
        T_PUSH
    } t_top_state;

endpackage

### design/rgl_axis.sv
// One axis: boundary memory, sequential cell search and midpoint/edge calculation.
module rgl_axis #(
    parameter int MAX_CELLS = rgl_pkg::MAX_CELLS_DEF,
    parameter int AW        = $clog2(MAX_CELLS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  rgl_pkg::t_axis_cmd                  i_cmd,
    input  logic [AW-1:0]                       i_waddr,
    input  logic [rgl_pkg::DATA_W-1:0]          i_wdata,
    input  logic signed [rgl_pkg::DATA_W-1:0]   i_point,
    input  logic [AW-1:0]                       i_cells,
    input  logic [AW-1:0]                       i_cell,
    output rgl_pkg::t_axis_stat                 o_stat,
    output logic [AW-1:0]                       o_cell,
    output logic [rgl_pkg::DATA_W-1:0]          o_mid,
    output logic [rgl_pkg::DATA_W-1:0]          o_edge
);

    localparam int DEPTH = MAX_CELLS + 1;

    logic [rgl_pkg::DATA_W-1:0]        r_mem [DEPTH];
    logic [rgl_pkg::DATA_W-1:0]        r_rdata;
    logic [AW-1:0]                     raddr;

    rgl_pkg::t_scan_state              r_state, n_state;
    logic [AW-1:0]                     r_idx;
    logic [AW-1:0]                     r_n;
    logic signed [rgl_pkg::DATA_W-1:0] r_point;
    logic [rgl_pkg::DATA_W-1:0]        r_a;
    logic                              r_found;
    logic [AW-1:0]                     r_cell;
    logic [rgl_pkg::DATA_W-1:0]        r_mid;
    logic signed [rgl_pkg::DATA_W:0]   r_edge;

    logic                              lt;
    logic signed [rgl_pkg::DATA_W:0]   sum;
    logic signed [rgl_pkg::DATA_W:0]   diff;
    logic                              start_ok;

    // boundary table, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    assign lt       = r_point < $signed(r_rdata);
    assign sum      = $signed({r_a[rgl_pkg::DATA_W-1], r_a})
                    + $signed({r_rdata[rgl_pkg::DATA_W-1], r_rdata});
    assign diff     = $signed({r_rdata[rgl_pkg::DATA_W-1], r_rdata})
                    - $signed({r_a[rgl_pkg::DATA_W-1], r_a});
    assign start_ok = (r_state == rgl_pkg::SC_IDLE) || (r_state == rgl_pkg::SC_DONE);

    always_comb begin
        n_state = r_state;
        raddr   = '0;
        case (r_state)
            rgl_pkg::SC_IDLE, rgl_pkg::SC_DONE: begin
                if (i_cmd.loc) begin
                    n_state = rgl_pkg::SC_FIRST;
                end else if (i_cmd.ctr) begin
                    raddr   = i_cell;
                    n_state = rgl_pkg::SC_CELL_A;
                end
            end
            rgl_pkg::SC_FIRST: begin
                // point below the first boundary: outside
                raddr   = r_n;
                n_state = lt ? rgl_pkg::SC_DONE : rgl_pkg::SC_LAST;
            end
            rgl_pkg::SC_LAST: begin
                raddr   = r_idx;
                n_state = lt ? rgl_pkg::SC_SCAN : rgl_pkg::SC_DONE;
            end
            rgl_pkg::SC_SCAN: begin
                raddr = r_idx + AW'(1);
                if (lt || (r_idx == r_n)) begin
                    n_state = rgl_pkg::SC_DONE;
                end
            end
            rgl_pkg::SC_CELL_A: begin
                raddr   = r_idx;
                n_state = rgl_pkg::SC_CELL_B;
            end
            rgl_pkg::SC_CELL_B: begin
                n_state = rgl_pkg::SC_DONE;
            end
            default: begin
                n_state = rgl_pkg::SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgl_pkg::SC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            if (start_ok && i_cmd.loc) begin
                r_idx   <= AW'(1);
                r_n     <= i_cells;
                r_point <= i_point;
                r_found <= 1'b0;
            end else if (start_ok && i_cmd.ctr) begin
                r_idx   <= i_cell + AW'(1);
                r_found <= 1'b0;
            end
            case (r_state)
                rgl_pkg::SC_SCAN: begin
                    // first upper boundary above the point closes the cell
                    if (lt || (r_idx == r_n)) begin
                        r_found <= 1'b1;
                        r_cell  <= r_idx - AW'(1);
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                rgl_pkg::SC_CELL_A: begin
                    r_a <= r_rdata;
                end
                rgl_pkg::SC_CELL_B: begin
                    // arithmetic shift rounds toward minus infinity
                    r_mid  <= sum[rgl_pkg::DATA_W:1];
                    r_edge <= diff;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_stat.done     = (r_state == rgl_pkg::SC_DONE);
    assign o_stat.found    = r_found;
    assign o_stat.edge_pos = !r_edge[rgl_pkg::DATA_W] && (|r_edge[rgl_pkg::DATA_W-1:0]);
    assign o_cell          = r_cell;
    assign o_mid           = r_mid;
    assign o_edge          = r_edge[rgl_pkg::DATA_W-1:0];

endmodule

### design/rgl_volume.sv
// Cell volume: three products on one shared 32x32 multiplier, then saturation.
module rgl_volume (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rgl_pkg::DATA_W-1:0]    i_dx,
    input  logic [rgl_pkg::DATA_W-1:0]    i_dy,
    input  logic [rgl_pkg::DATA_W-1:0]    i_dz,
    output logic                          o_done,
    output logic [rgl_pkg::VOL_W-1:0]     o_volume
);

    localparam int PW = 2 * rgl_pkg::DATA_W;

    rgl_pkg::t_vol_state          r_state, n_state;
    logic [PW-1:0]                r_prod;
    logic [PW-1:0]                r_hi;
    logic [rgl_pkg::DATA_W-1:0]   r_lo;
    logic [rgl_pkg::DATA_W-1:0]   r_dz;
    logic [rgl_pkg::VOL_W-1:0]    r_vol;

    logic [rgl_pkg::DATA_W-1:0]   op_a;
    logic [rgl_pkg::DATA_W-1:0]   op_b;
    logic [PW-1:0]                product;
    logic [PW:0]                  sum;
    logic                         start_ok;

    assign start_ok = (r_state == rgl_pkg::V_IDLE) || (r_state == rgl_pkg::V_DONE);

    always_comb begin
        case (r_state)
            rgl_pkg::V_HI: begin
                op_a = r_prod[PW-1:rgl_pkg::DATA_W];
                op_b = r_dz;
            end
            rgl_pkg::V_LO: begin
                op_a = r_prod[rgl_pkg::DATA_W-1:0];
                op_b = r_dz;
            end
            default: begin
                op_a = i_dx;
                op_b = i_dy;
            end
        endcase
    end

    assign product = PW'(op_a) * PW'(op_b);
    assign sum     = {1'b0, r_hi} + (PW + 1)'(r_lo);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rgl_pkg::V_IDLE, rgl_pkg::V_DONE: begin
                if (i_start) begin
                    n_state = rgl_pkg::V_HI;
                end
            end
            rgl_pkg::V_HI:  n_state = rgl_pkg::V_LO;
            rgl_pkg::V_LO:  n_state = rgl_pkg::V_SUM;
            rgl_pkg::V_SUM: n_state = rgl_pkg::V_DONE;
            default:        n_state = rgl_pkg::V_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgl_pkg::V_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_ok && i_start) begin
            r_prod <= product;
            r_dz   <= i_dz;
        end
        case (r_state)
            rgl_pkg::V_HI: r_hi <= product;
            rgl_pkg::V_LO: r_lo <= product[PW-1:rgl_pkg::DATA_W];
            rgl_pkg::V_SUM: begin
                // anything at or above 2^63 clamps to the maximum
                if (|sum[PW:rgl_pkg::VOL_W]) begin
                    r_vol <= '1;
                end else begin
                    r_vol <= sum[rgl_pkg::VOL_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    assign o_done   = (r_state == rgl_pkg::V_DONE);
    assign o_volume = r_vol;

endmodule

### design/rectilinear_grid_locator.sv
// Top level of the rectilinear grid locator: control sequencer, config and output register.
//
//  channel  | direction | transfer when           | contents
//  s stream | in        | i_s_tvalid & o_s_tready | op, axis (tuser); slot, bound, point, cell
//  m stream | out       | o_m_tvalid & i_m_tready | index, centers, volume; inside, size_ok
//  cfg      | in        | i_cfg_we                | cells_x, cells_y, cells_z
//
// Load and unused ops go from accept straight to the output push. Locate scans the
// three axes side by side, each axis memory serving one boundary read per cycle, so
// its run grows with the largest cell count of the three axes. Center/volume also
// runs the shared multiplier of the volume unit when every edge is positive. One
// item is in work at a time; a new one is taken while the previous result waits on
// the output.
// Reset (synchronous, active low) sets all cell counts to 1; boundary tables are
// not cleared.
module rectilinear_grid_locator #(
    parameter int MAX_CELLS = rgl_pkg::MAX_CELLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slot[8:0], bound_value[40:9], point_x[72:41], point_y[104:73],
    // point_z[136:105], cell_x[144:137], cell_y[152:145], cell_z[160:153]
    input  logic [167:0]                       i_s_tdata,
    // op[1:0], axis[3:2]
    input  logic [3:0]                         i_s_tuser,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // cell_index[23:0], center_x[55:24], center_y[87:56], center_z[119:88],
    // volume[182:120]
    output logic [183:0]                       o_m_tdata,
    // inside_res[0], size_ok[1]
    output logic [1:0]                         o_m_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic                               i_cfg_we,
    input  logic [rgl_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [rgl_pkg::CFG_W-1:0]          i_cfg_wdata
);

    localparam int AW  = $clog2(MAX_CELLS + 1);
    localparam int SW  = (AW > rgl_pkg::SLOT_W) ? AW : rgl_pkg::SLOT_W;
    localparam int CW  = (AW > rgl_pkg::CELL_IN_W) ? AW : rgl_pkg::CELL_IN_W;
    localparam int IW  = rgl_pkg::IDX_W;
    localparam int DW  = rgl_pkg::DATA_W;

    // input fields
    logic [rgl_pkg::SLOT_W-1:0]    in_slot;
    logic [DW-1:0]                 in_bound;
    logic signed [DW-1:0]          in_px, in_py, in_pz;
    logic [rgl_pkg::CELL_IN_W-1:0] in_cx, in_cy, in_cz;
    rgl_pkg::t_op                  in_op;
    logic [1:0]                    in_axis;

    assign in_slot  = i_s_tdata[8:0];
    assign in_bound = i_s_tdata[40:9];
    assign in_px    = i_s_tdata[72:41];
    assign in_py    = i_s_tdata[104:73];
    assign in_pz    = i_s_tdata[136:105];
    assign in_cx    = i_s_tdata[144:137];
    assign in_cy    = i_s_tdata[152:145];
    assign in_cz    = i_s_tdata[160:153];
    assign in_op    = rgl_pkg::t_op'(i_s_tuser[1:0]);
    assign in_axis  = i_s_tuser[3:2];

    logic [rgl_pkg::CFG_W-1:0] r_cells_x, r_cells_y, r_cells_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_x <= rgl_pkg::CFG_W'(1);
            r_cells_y <= rgl_pkg::CFG_W'(1);
            r_cells_z <= rgl_pkg::CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rgl_pkg::REG_CELLS_X: r_cells_x <= i_cfg_wdata;
                rgl_pkg::REG_CELLS_Y: r_cells_y <= i_cfg_wdata;
                rgl_pkg::REG_CELLS_Z: r_cells_z <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    function automatic logic [AW-1:0] eff_cells(input logic [rgl_pkg::CFG_W-1:0] v);
        logic [SW-1:0] e;
        e = SW'(v);
        if (e == '0) begin
            e = SW'(1);
        end else if (e > SW'(MAX_CELLS)) begin
            e = SW'(MAX_CELLS);
        end
        return e[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] clamp_cell(input logic [rgl_pkg::CELL_IN_W-1:0] c,
                                                 input logic [AW-1:0] n);
        logic [CW-1:0] ce;
        logic [CW-1:0] ne;
        ce = CW'(c);
        ne = CW'(n);
        if (ce >= ne) begin
            ce = ne - CW'(1);
        end
        return ce[AW-1:0];
    endfunction

    logic [AW-1:0] nx, ny, nz;
    logic [AW-1:0] cx_cl, cy_cl, cz_cl;
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic [AW-1:0] waddr;

    assign nx       = eff_cells(r_cells_x);
    assign ny       = eff_cells(r_cells_y);
    assign nz       = eff_cells(r_cells_z);
    assign cx_cl    = clamp_cell(in_cx, nx);
    assign cy_cl    = clamp_cell(in_cy, ny);
    assign cz_cl    = clamp_cell(in_cz, nz);
    assign slot_ext = SW'(in_slot);
    assign slot_ok  = slot_ext <= SW'(MAX_CELLS);
    assign waddr    = slot_ext[AW-1:0];

    rgl_pkg::t_top_state r_state, n_state;
    rgl_pkg::t_op        r_op;
    logic                accept;
    logic                push;
    logic                r_m_valid;

    assign o_s_tready = (r_state == rgl_pkg::T_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign push       = (r_state == rgl_pkg::T_PUSH) && (!r_m_valid || i_m_tready);

    // axis units
    rgl_pkg::t_axis_cmd  cmd_x, cmd_y, cmd_z;
    rgl_pkg::t_axis_stat st_x, st_y, st_z;
    logic [AW-1:0]       cell_x, cell_y, cell_z;
    logic [DW-1:0]       mid_x, mid_y, mid_z;
    logic [DW-1:0]       edge_x, edge_y, edge_z;
    logic                is_load;

    assign is_load = accept && (in_op == rgl_pkg::OP_LOAD) && slot_ok;

    assign cmd_x.wr  = is_load && (in_axis == rgl_pkg::AXIS_X);
    assign cmd_y.wr  = is_load && (in_axis == rgl_pkg::AXIS_Y);
    assign cmd_z.wr  = is_load && (in_axis == rgl_pkg::AXIS_Z);
    assign cmd_x.loc = accept && (in_op == rgl_pkg::OP_LOCATE);
    assign cmd_y.loc = cmd_x.loc;
    assign cmd_z.loc = cmd_x.loc;
    assign cmd_x.ctr = accept && (in_op == rgl_pkg::OP_CELL);
    assign cmd_y.ctr = cmd_x.ctr;
    assign cmd_z.ctr = cmd_x.ctr;

    rgl_axis #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_axis_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_x),
        .i_waddr (waddr),
        .i_wdata (in_bound),
        .i_point (in_px),
        .i_cells (nx),
        .i_cell  (cx_cl),
        .o_stat  (st_x),
        .o_cell  (cell_x),
        .o_mid   (mid_x),
        .o_edge  (edge_x)
    );

    rgl_axis #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_axis_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_y),
        .i_waddr (waddr),
        .i_wdata (in_bound),
        .i_point (in_py),
        .i_cells (ny),
        .i_cell  (cy_cl),
        .o_stat  (st_y),
        .o_cell  (cell_y),
        .o_mid   (mid_y),
        .o_edge  (edge_y)
    );

    rgl_axis #(.MAX_CELLS(MAX_CELLS), .AW(AW)) u_axis_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_z),
        .i_waddr (waddr),
        .i_wdata (in_bound),
        .i_point (in_pz),
        .i_cells (nz),
        .i_cell  (cz_cl),
        .o_stat  (st_z),
        .o_cell  (cell_z),
        .o_mid   (mid_z),
        .o_edge  (edge_z)
    );

    logic all_done, all_found, all_pos;
    logic vol_start, vol_done;
    logic [rgl_pkg::VOL_W-1:0] vol;

    assign all_done  = st_x.done && st_y.done && st_z.done;
    assign all_found = st_x.found && st_y.found && st_z.found;
    assign all_pos   = st_x.edge_pos && st_y.edge_pos && st_z.edge_pos;
    assign vol_start = (r_state == rgl_pkg::T_AXES) && all_done
                    && (r_op == rgl_pkg::OP_CELL) && all_pos;

    rgl_volume u_volume (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (vol_start),
        .i_dx     (edge_x),
        .i_dy     (edge_y),
        .i_dz     (edge_z),
        .o_done   (vol_done),
        .o_volume (vol)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            rgl_pkg::T_IDLE: begin
                if (accept) begin
                    if (in_op == rgl_pkg::OP_LOCATE || in_op == rgl_pkg::OP_CELL) begin
                        n_state = rgl_pkg::T_AXES;
                    end else begin
                        n_state = rgl_pkg::T_PUSH;
                    end
                end
            end
            rgl_pkg::T_AXES: begin
                if (all_done) begin
                    if (r_op == rgl_pkg::OP_LOCATE && all_found) begin
                        n_state = rgl_pkg::T_IDX1;
                    end else if (r_op == rgl_pkg::OP_CELL && all_pos) begin
                        n_state = rgl_pkg::T_VOL;
                    end else begin
                        n_state = rgl_pkg::T_PUSH;
                    end
                end
            end
            rgl_pkg::T_IDX1: n_state = rgl_pkg::T_IDX2;
            rgl_pkg::T_IDX2: n_state = rgl_pkg::T_PUSH;
            rgl_pkg::T_VOL: begin
                if (vol_done) begin
                    n_state = rgl_pkg::T_PUSH;
                end
            end
            rgl_pkg::T_PUSH: begin
                if (push) begin
                    n_state = rgl_pkg::T_IDLE;
                end
            end
            default: n_state = rgl_pkg::T_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rgl_pkg::T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // result being built
    logic [AW-1:0]             r_nx, r_ny;
    logic [IW-1:0]             r_res_index;
    logic                      r_res_inside;
    logic [DW-1:0]             r_res_cx, r_res_cy, r_res_cz;
    logic [rgl_pkg::VOL_W-1:0] r_res_vol;
    logic                      r_res_ok;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op         <= in_op;
            r_nx         <= nx;
            r_ny         <= ny;
            r_res_index  <= '0;
            r_res_inside <= 1'b0;
            r_res_cx     <= '0;
            r_res_cy     <= '0;
            r_res_cz     <= '0;
            r_res_vol    <= '0;
            r_res_ok     <= 1'b0;
        end
        case (r_state)
            rgl_pkg::T_AXES: begin
                if (all_done && r_op == rgl_pkg::OP_CELL) begin
                    r_res_cx <= mid_x;
                    r_res_cy <= mid_y;
                    r_res_cz <= mid_z;
                    r_res_ok <= all_pos;
                end
            end
            rgl_pkg::T_IDX1: begin
                r_res_index <= IW'(IW'(cell_z) * IW'(r_ny) + IW'(cell_y));
            end
            rgl_pkg::T_IDX2: begin
                // index wraps to its field width
                r_res_index  <= IW'(r_res_index * IW'(r_nx) + IW'(cell_x));
                r_res_inside <= 1'b1;
            end
            rgl_pkg::T_VOL: begin
                if (vol_done) begin
                    r_res_vol <= vol;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    logic [183:0] r_m_tdata;
    logic [1:0]   r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (push) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_m_tdata <= {1'b0, r_res_vol, r_res_cz, r_res_cy, r_res_cx, r_res_index};
            r_m_tuser <= {r_res_ok, r_res_inside};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

### test/rectilinear_grid_locator_test.sv
// Self-checking testbench for the rectilinear grid locator: random stream traffic, own predictor.
`timescale 1ns / 1ps

module rectilinear_grid_locator_test;

    localparam logic [1:0]                     AXIS_BAD     = 2'd3;
    localparam logic [rgl_pkg::CFG_ADDR_W-1:0] REG_UNUSED   = 2'd3;
    localparam logic [62:0]                    VOL_CAP      = '1;
    localparam int                             CYCLE_LIMIT  = 2_000_000;
    localparam int                             FLUSH_CYCLES = 300;

    typedef struct packed {
        rgl_pkg::t_op     op;
        logic [1:0]       axis;
        logic [8:0]       slot;
        logic [31:0]      bound;
        logic [2:0][31:0] pt;     // [0] x, [1] y, [2] z
        logic [2:0][7:0]  box;
    } t_grid_req;

    typedef struct packed {
        logic [23:0]      idx;
        logic             found;
        logic [2:0][31:0] mid;
        logic [62:0]      vol;
        logic             size_ok;
    } t_grid_resp;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic [167:0]                   i_s_tdata;
    logic [3:0]                     i_s_tuser;
    logic                           i_s_tvalid  = 1'b0;
    logic                           o_s_tready;
    logic [183:0]                   o_m_tdata;
    logic [1:0]                     o_m_tuser;
    logic                           o_m_tvalid;
    logic                           i_m_tready  = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [rgl_pkg::CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [rgl_pkg::CFG_W-1:0]      i_cfg_wdata = '0;

    t_grid_req  s_item = '0;
    t_grid_req  stim_items [$];
    t_grid_resp pending_answers [$];

    // predictor state
    logic signed [31:0] bound_tab [3][0:256];
    logic [8:0]         cells_reg [3];

    // generator's view of the tables, so well-formed points can be aimed at cells
    logic signed [31:0] gen_bound [3][0:256];
    int                 gen_cells [3];

    bit steady_run     = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;
    int items_queued   = 0;
    int answers_seen   = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    assign i_s_tdata = {7'd0, s_item.box, s_item.pt, s_item.bound, s_item.slot};
    assign i_s_tuser = {s_item.axis, s_item.op};

    rectilinear_grid_locator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic int active_cells(logic [8:0] v);
        if (v == 9'd0) return 1;
        if (v > 9'(rgl_pkg::MAX_CELLS_DEF)) return rgl_pkg::MAX_CELLS_DEF;
        return int'(v);
    endfunction

    // first k with b[k] <= p < b[k+1], only when p lies in [b[0], b[n])
    function automatic bit find_slab(int ax, int n, logic signed [31:0] p, output int k_out);
        k_out = 0;
        if (p < bound_tab[ax][0] || p >= bound_tab[ax][n]) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (p >= bound_tab[ax][k] && p < bound_tab[ax][k + 1]) begin
                k_out = k;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_grid_resp grid_answer(t_grid_req r);
        t_grid_resp   a;
        int           n [3];
        int           c [3];
        bit           hit;
        longint       lo, hi;
        longint       span [3];
        logic [127:0] prod;
        a = '0;
        for (int ax = 0; ax < 3; ax++) n[ax] = active_cells(cells_reg[ax]);
        case (r.op)
            rgl_pkg::OP_LOAD: begin
                if (r.axis != AXIS_BAD && r.slot <= 9'(rgl_pkg::MAX_CELLS_DEF))
                    bound_tab[r.axis][r.slot] = r.bound;
            end
            rgl_pkg::OP_LOCATE: begin
                hit = 1'b1;
                for (int ax = 0; ax < 3; ax++)
                    if (hit) hit = find_slab(ax, n[ax], r.pt[ax], c[ax]);
                if (hit) begin
                    a.idx   = 24'((c[2] * n[1] + c[1]) * n[0] + c[0]);
                    a.found = 1'b1;
                end
            end
            rgl_pkg::OP_CELL: begin
                for (int ax = 0; ax < 3; ax++) begin
                    c[ax]    = (r.box[ax] >= n[ax]) ? n[ax] - 1 : int'(r.box[ax]);
                    lo       = bound_tab[ax][c[ax]];
                    hi       = bound_tab[ax][c[ax] + 1];
                    a.mid[ax] = 32'((lo + hi) >>> 1);   // floor of the half sum
                    span[ax] = hi - lo;
                end
                if (span[0] > 0 && span[1] > 0 && span[2] > 0) begin
                    prod = 128'(span[0]) * 128'(span[1]) * 128'(span[2]);
                    prod = prod >> 32;
                    a.vol     = (prod > 128'(VOL_CAP)) ? VOL_CAP : prod[62:0];
                    a.size_ok = 1'b1;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("[%0t] result %0d: %s is %h, expected %h",
                     $realtime, answers_seen, what, got, want);
    endtask

    task automatic check_answer();
        t_grid_resp got;
        t_grid_resp want;
        got.idx     = o_m_tdata[23:0];
        got.mid     = o_m_tdata[119:24];
        got.vol     = o_m_tdata[182:120];
        got.found   = o_m_tuser[0];
        got.size_ok = o_m_tuser[1];
        if (pending_answers.size() == 0) begin
            flag_mismatch("result with nothing pending", 64'd0, 64'd0);
            return;
        end
        want = pending_answers.pop_front();
        if (got.idx !== want.idx) flag_mismatch("cell_index", got.idx, want.idx);
        if (got.found !== want.found) flag_mismatch("inside_res", got.found, want.found);
        if (got.mid[0] !== want.mid[0]) flag_mismatch("center_x", got.mid[0], want.mid[0]);
        if (got.mid[1] !== want.mid[1]) flag_mismatch("center_y", got.mid[1], want.mid[1]);
        if (got.mid[2] !== want.mid[2]) flag_mismatch("center_z", got.mid[2], want.mid[2]);
        if (got.vol !== want.vol) flag_mismatch("volume", got.vol, want.vol);
        if (got.size_ok !== want.size_ok) flag_mismatch("size_ok", got.size_ok, want.size_ok);
        answers_seen++;
    endtask

    // mostly back to back, sometimes a few cycles, rarely a long pause
    function automatic int idle_len();
        int r;
        if (steady_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_grid_req noise_fields();
        t_grid_req r;
        r.op    = rgl_pkg::t_op'($urandom_range(0, 3));
        r.axis  = 2'($urandom);
        r.slot  = 9'($urandom);
        r.bound = $urandom;
        for (int ax = 0; ax < 3; ax++) begin
            r.pt[ax]  = $urandom;
            r.box[ax] = 8'($urandom);
        end
        return r;
    endfunction

    function automatic t_grid_req load_req(logic [1:0] ax, logic [8:0] s, logic [31:0] v);
        t_grid_req r;
        r       = noise_fields();
        r.op    = rgl_pkg::OP_LOAD;
        r.axis  = ax;
        r.slot  = s;
        r.bound = v;
        return r;
    endfunction

    function automatic t_grid_req point_req(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_grid_req r;
        r    = noise_fields();
        r.op = rgl_pkg::OP_LOCATE;
        r.pt = {z, y, x};
        return r;
    endfunction

    function automatic t_grid_req box_req(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        t_grid_req r;
        r     = noise_fields();
        r.op  = rgl_pkg::OP_CELL;
        r.box = {z, y, x};
        return r;
    endfunction

    function automatic t_grid_req random_op();
        t_grid_req r;
        int        pick, ax, k, s;
        longint    lo, hi, p;
        r    = noise_fields();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // point aimed at a cell, its corners or just outside the grid
            r.op = rgl_pkg::OP_LOCATE;
            for (ax = 0; ax < 3; ax++) begin
                k  = $urandom_range(0, gen_cells[ax] - 1);
                lo = gen_bound[ax][k];
                hi = gen_bound[ax][k + 1];
                case ($urandom_range(0, 9))
                    0: p = gen_bound[ax][0];
                    1: p = gen_bound[ax][gen_cells[ax]];
                    2: p = longint'(gen_bound[ax][0]) - 1;
                    3: p = lo;
                    default: p = (hi > lo) ? lo + longint'($urandom) % (hi - lo) : lo;
                endcase
                r.pt[ax] = p[31:0];
            end
        end else if (pick < 60) begin
            r.op = rgl_pkg::OP_CELL;
            for (ax = 0; ax < 3; ax++)
                if ($urandom_range(0, 2) != 0)
                    r.box[ax] = 8'($urandom_range(0, gen_cells[ax] - 1));
        end else if (pick < 75) begin
            // rewrite a live boundary: mostly a nudge, which may reorder or merge edges
            ax = $urandom_range(0, 2);
            s  = $urandom_range(0, gen_cells[ax]);
            if ($urandom_range(0, 9) < 7)
                p = longint'(gen_bound[ax][s]) + longint'($urandom_range(0, 131072)) - 65536;
            else
                p = longint'($urandom);
            r = load_req(2'(ax), 9'(s), p[31:0]);
            gen_bound[ax][s] = r.bound;
        end else if (pick < 85) begin
            r.op = rgl_pkg::OP_LOCATE;
        end else if (pick < 90) begin
            r.op = rgl_pkg::OP_NONE;
        end else if (pick < 95) begin
            r.op = rgl_pkg::OP_LOAD;
            if ($urandom_range(0, 1) != 0)
                r.axis = AXIS_BAD;
            else
                r.slot = 9'($urandom_range(rgl_pkg::MAX_CELLS_DEF + 1, 511));
        end else begin
            ax = $urandom_range(0, 2);
            if (gen_cells[ax] < rgl_pkg::MAX_CELLS_DEF)
                s = $urandom_range(gen_cells[ax] + 1, rgl_pkg::MAX_CELLS_DEF);
            else
                s = $urandom_range(0, rgl_pkg::MAX_CELLS_DEF);
            r = load_req(2'(ax), 9'(s), $urandom);
            gen_bound[ax][s] = r.bound;
        end
        return r;
    endfunction

    task automatic queue_item(input t_grid_req r);
        stim_items.push_back(r);
        items_queued++;
    endtask

    // increasing boundaries, step size picked per axis so grids run from fine to coarse
    task automatic fill_axis(input int ax);
        longint v;
        int     cap;
        v   = longint'($urandom_range(0, 32'h6000_0000)) - 64'sh4000_0000;
        cap = $urandom_range(1, (1 << 30) / gen_cells[ax]);
        for (int s = 0; s <= gen_cells[ax]; s++) begin
            gen_bound[ax][s] = v[31:0];
            queue_item(load_req(2'(ax), 9'(s), v[31:0]));
            v += longint'($urandom_range(1, cap));
        end
    endtask

    task automatic wait_drained();
        while (answers_seen != items_queued) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rgl_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [rgl_pkg::CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
    endtask

    task automatic run_phase(input logic [8:0] vx, input logic [8:0] vy, input logic [8:0] vz,
                             input int n_ops, input bit steady);
        // nothing new goes out until every result of the previous phase is back
        wait_drained();
        steady_run <= steady;
        write_reg(rgl_pkg::REG_CELLS_X, vx);
        write_reg(rgl_pkg::REG_CELLS_Y, vy);
        write_reg(rgl_pkg::REG_CELLS_Z, vz);
        write_reg(REG_UNUSED, 9'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gen_cells[0] = active_cells(vx);
        gen_cells[1] = active_cells(vy);
        gen_cells[2] = active_cells(vz);
        for (int ax = 0; ax < 3; ax++) fill_axis(ax);
        repeat (n_ops) queue_item(random_op());
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (send_gap > 0) begin
                i_s_tvalid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (stim_items.size() > 0) begin
                s_item     <= stim_items.pop_front();
                i_s_tvalid <= 1'b1;
                send_gap   <= idle_len();
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // accepted input transfer -> expected result
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            pending_answers.push_back(grid_answer(s_item));
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cells_reg[0] <= 9'd1;
            cells_reg[1] <= 9'd1;
            cells_reg[2] <= 9'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rgl_pkg::REG_CELLS_X: cells_reg[0] <= i_cfg_wdata;
                rgl_pkg::REG_CELLS_Y: cells_reg[1] <= i_cfg_wdata;
                rgl_pkg::REG_CELLS_Z: cells_reg[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // receiver: check output transfers, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_answer();
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else if (!steady_run && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                stall_left <= idle_len();
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_grid_req r;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one cell per axis after reset; x spans the whole number range
        queue_item(load_req(rgl_pkg::AXIS_X, 9'd0, 32'h8000_0000));
        queue_item(load_req(rgl_pkg::AXIS_X, 9'd1, 32'h7fff_ffff));
        queue_item(load_req(rgl_pkg::AXIS_Y, 9'd0, 32'h0000_0000));
        queue_item(load_req(rgl_pkg::AXIS_Y, 9'd1, 32'h0001_0000));
        queue_item(load_req(rgl_pkg::AXIS_Z, 9'd0, 32'hffff_0000));
        queue_item(load_req(rgl_pkg::AXIS_Z, 9'd1, 32'h0000_8000));
        queue_item(point_req(32'h8000_0000, 32'h0000_0000, 32'hffff_0000));
        queue_item(point_req(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000));
        queue_item(point_req(32'h0000_0000, 32'h0001_0000, 32'h0000_0000));
        queue_item(point_req(32'hffff_ffff, 32'h0000_ffff, 32'h0000_7fff));
        queue_item(box_req(8'd0, 8'd0, 8'd0));
        queue_item(box_req(8'd255, 8'd255, 8'd255));   // clamped to the last cell
        // full-range edges on all axes: volume saturates
        queue_item(load_req(rgl_pkg::AXIS_Y, 9'd0, 32'h8000_0000));
        queue_item(load_req(rgl_pkg::AXIS_Y, 9'd1, 32'h7fff_ffff));
        queue_item(load_req(rgl_pkg::AXIS_Z, 9'd0, 32'h8000_0000));
        queue_item(load_req(rgl_pkg::AXIS_Z, 9'd1, 32'h7fff_ffff));
        queue_item(box_req(8'd0, 8'd0, 8'd0));
        // zero-length y edge
        queue_item(load_req(rgl_pkg::AXIS_Y, 9'd1, 32'h8000_0000));
        queue_item(box_req(8'd1, 8'd2, 8'd3));
        queue_item(point_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
        // loads that must be dropped, then the top slot, then the unused op
        queue_item(load_req(AXIS_BAD, 9'd0, 32'h1234_5678));
        queue_item(load_req(rgl_pkg::AXIS_X, 9'd300, 32'h5555_aaaa));
        queue_item(load_req(rgl_pkg::AXIS_X, 9'd256, 32'h0000_0000));
        r    = '1;
        r.op = rgl_pkg::OP_NONE;
        queue_item(r);

        run_phase(9'd3,   9'd2,   9'd4,   90,  1'b0);
        run_phase(9'd0,   9'd511, 9'd2,   60,  1'b1);
        run_phase(9'd8,   9'd7,   9'd6,   100, 1'b1);
        run_phase(9'd1,   9'd1,   9'd1,   40,  1'b0);
        run_phase(9'd16,  9'd3,   9'd9,   60,  1'b0);

        wait_drained();
        repeat (FLUSH_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
